### rtl/ppsf_pkg.sv
// ----------------------------------------------------------------------------
// ppsf_pkg: shared constants and types for the path point spacing filter
// Field widths, configuration defaults and the result queue status bundle.
// ----------------------------------------------------------------------------
package ppsf_pkg;

	localparam int COORD_BITS_DEF = 31;
	localparam int SPEED_W        = 16;
	localparam int HEADING_W      = 16;
	localparam int SPACING_W      = 16;
	localparam int LIM_W          = 2 * SPACING_W;
	localparam int SQ_BITS        = 16;

	localparam logic [SPACING_W-1:0] SPACING_RST = 16'd10;

	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic room2;
		logic nonempty;
	} fifo_stat_t;

endpackage

### rtl/ppsf_dist.sv
// ----------------------------------------------------------------------------
// ppsf_dist: planar spacing test
// Flags a point whose squared planar distance from the pending point is
// strictly greater than the squared spacing limit.
// ----------------------------------------------------------------------------
module ppsf_dist
	import ppsf_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic [COORD_BITS-1:0] ax,
	input  logic [COORD_BITS-1:0] ay,
	input  logic [COORD_BITS-1:0] bx,
	input  logic [COORD_BITS-1:0] by,
	input  logic [LIM_W-1:0]      lim,
	output logic                  far
);

	localparam int DW = COORD_BITS + 1;

	logic [DW-1:0]      dx_d, dy_d, dx_a, dy_a;
	logic               big;
	logic [2*SQ_BITS-1:0] sq_x, sq_y;
	logic [2*SQ_BITS:0]   sum;

	assign dx_d = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
	assign dy_d = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
	assign dx_a = dx_d[DW-1] ? (~dx_d + DW'(1)) : dx_d;
	assign dy_a = dy_d[DW-1] ? (~dy_d + DW'(1)) : dy_d;

	// any offset of 2^16 or more already beats the largest possible limit
	assign big = (|dx_a[DW-1:SQ_BITS]) | (|dy_a[DW-1:SQ_BITS]);

	assign sq_x = (2*SQ_BITS)'(dx_a[SQ_BITS-1:0]) * (2*SQ_BITS)'(dx_a[SQ_BITS-1:0]);
	assign sq_y = (2*SQ_BITS)'(dy_a[SQ_BITS-1:0]) * (2*SQ_BITS)'(dy_a[SQ_BITS-1:0]);
	assign sum  = (2*SQ_BITS+1)'(sq_x) + (2*SQ_BITS+1)'(sq_y);

	assign far = big | (sum > (2*SQ_BITS+1)'(lim));

endmodule

### rtl/ppsf_out_fifo.sv
// ----------------------------------------------------------------------------
// ppsf_out_fifo: result queue
// Small register queue that takes up to two words per clock and hands one
// word per clock to the output channel while the reader does not stall.
// ----------------------------------------------------------------------------
module ppsf_out_fifo
	import ppsf_pkg::*;
#(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [1:0]   wr_cnt,
	input  logic [W-1:0] wr_a,
	input  logic [W-1:0] wr_b,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output fifo_stat_t   stat
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [W-1:0]  mem [FIFO_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          rd_go;

	assign rd_go         = rd_en & stat.nonempty;
	assign rd_data       = mem[rp_q];
	assign stat.nonempty = (cnt_q != '0);
	assign stat.room2    = (cnt_q <= CW'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			mem[wp_q] <= wr_a;
		end
		if (wr_cnt == 2'd2) begin
			mem[wp_q + PW'(1)] <= wr_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(wr_cnt);
			rp_q  <= rp_q + PW'(rd_go);
			cnt_q <= cnt_q + CW'(wr_cnt) - CW'(rd_go);
		end
	end

endmodule

### rtl/path_point_spacing_filter_core.sv
// ----------------------------------------------------------------------------
// path_point_spacing_filter_core: minimum distance decimation of a path
// Keeps a pending point, releases it when a new point lies farther than the
// configured spacing, merges closer points by minimum speed, flushes on end.
// ----------------------------------------------------------------------------
// An accepted point waits in the input register, then its results are queued.
// Throughput: one point per clock while the queue has room for two words; the
// input register feeds the spacing test (combinational) on the pending point.
// A point that ends the path after a release gives two words, written together
// into a four-entry result queue and read out in order.
// Reset: no pending point, empty queue, spacing 10 mm.
module path_point_spacing_filter_core
	import ppsf_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [SPACING_W-1:0]        cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic signed [SPEED_W-1:0]   speed,
	input  logic [HEADING_W-1:0]        heading,
	input  logic                        path_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic signed [COORD_BITS-1:0] out_z,
	output logic signed [SPEED_W-1:0]   out_speed,
	output logic [HEADING_W-1:0]        out_heading,
	output logic                        out_last
);

	localparam int PW = 3 * COORD_BITS + SPEED_W + HEADING_W;
	localparam int W  = PW + 1;
	localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(SPACING_RST) * LIM_W'(SPACING_RST);

	// input register
	logic                          v_s1;
	logic signed [COORD_BITS-1:0]  x_s1, y_s1, z_s1;
	logic signed [SPEED_W-1:0]     speed_s1;
	logic [HEADING_W-1:0]          heading_s1;
	logic                          path_end_s1;

	// pending point
	logic                          pend_valid_q;
	logic signed [COORD_BITS-1:0]  pend_x_q, pend_y_q, pend_z_q;
	logic signed [SPEED_W-1:0]     pend_speed_q;
	logic [HEADING_W-1:0]          pend_heading_q;

	logic [LIM_W-1:0]              lim_q;

	logic                          far, proc, accept, load, e0, e1;
	logic signed [SPEED_W-1:0]     nx_speed;
	logic [PW-1:0]                 old_pt, nx_pt;
	logic [1:0]                    wr_cnt;
	logic [W-1:0]                  wr_a, wr_b, rd_data;
	fifo_stat_t                    stat;

	ppsf_dist #(.COORD_BITS(COORD_BITS)) u_dist (
		.ax  (x_s1),
		.ay  (y_s1),
		.bx  (pend_x_q),
		.by  (pend_y_q),
		.lim (lim_q),
		.far (far)
	);

	// handle the held word only when the queue can take two results
	assign proc     = v_s1 & stat.room2;
	assign in_stall = v_s1 & ~stat.room2;
	assign accept   = in_valid & ~in_stall;

	assign load     = ~pend_valid_q | far;
	assign nx_speed = load ? speed_s1 :
	                  ((speed_s1 < pend_speed_q) ? speed_s1 : pend_speed_q);

	assign old_pt = {pend_x_q, pend_y_q, pend_z_q, pend_speed_q, pend_heading_q};
	assign nx_pt  = load ? {x_s1, y_s1, z_s1, speed_s1, heading_s1}
	                     : {pend_x_q, pend_y_q, pend_z_q, nx_speed, pend_heading_q};

	assign e0     = proc & pend_valid_q & far;
	assign e1     = proc & path_end_s1;
	assign wr_cnt = {1'b0, e0} + {1'b0, e1};
	assign wr_a   = e0 ? {old_pt, 1'b0} : {nx_pt, 1'b1};
	assign wr_b   = {nx_pt, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			pend_valid_q <= 1'b0;
			lim_q        <= LIM_RST;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (proc) begin
				v_s1 <= 1'b0;
			end
			if (proc) begin
				pend_valid_q <= ~path_end_s1;
			end
			if (cfg_wr_en) begin
				lim_q <= LIM_W'(cfg_wr_data) * LIM_W'(cfg_wr_data);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1        <= pos_x;
			y_s1        <= pos_y;
			z_s1        <= pos_z;
			speed_s1    <= speed;
			heading_s1  <= heading;
			path_end_s1 <= path_end;
		end
		if (proc) begin
			{pend_x_q, pend_y_q, pend_z_q, pend_speed_q, pend_heading_q} <= nx_pt;
		end
	end

	ppsf_out_fifo #(.W(W)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_cnt  (wr_cnt),
		.wr_a    (wr_a),
		.wr_b    (wr_b),
		.rd_en   (~out_stall),
		.rd_data (rd_data),
		.stat    (stat)
	);

	assign out_valid   = stat.nonempty;
	assign out_x       = rd_data[W-1 -: COORD_BITS];
	assign out_y       = rd_data[W-1-COORD_BITS -: COORD_BITS];
	assign out_z       = rd_data[W-1-2*COORD_BITS -: COORD_BITS];
	assign out_speed   = rd_data[HEADING_W+SPEED_W -: SPEED_W];
	assign out_heading = rd_data[HEADING_W:1];
	assign out_last    = rd_data[0];

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && path_end_s1) |=> !pend_valid_q)
		else $error("pending point survived a path end");

	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !path_end_s1) |=> pend_valid_q)
		else $error("pending point lost without a path end");

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !proc) |=> v_s1)
		else $error("held input word dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && pend_valid_q && !far) |=> (pend_speed_q <= $past(pend_speed_q)))
		else $error("merged speed rose above pending speed");
`endif

endmodule

### verif/tb_path_point_spacing_filter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_path_point_spacing_filter_core: self-checking bench for the spacing filter
// Streams directed and random paths under several spacing settings, predicts
// the kept points with an in-bench decimation model and checks every word.
// ----------------------------------------------------------------------------
module tb_path_point_spacing_filter_core
	import ppsf_pkg::*;
();

	localparam int CB          = COORD_BITS_DEF;
	localparam int QUIET_LIMIT = 4000;
	localparam int LONG_HOLD   = 300;
	localparam int PHASE_ITEMS = 275;

	localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

	typedef struct packed {
		logic signed [CB-1:0]      x;
		logic signed [CB-1:0]      y;
		logic signed [CB-1:0]      z;
		logic signed [SPEED_W-1:0] spd;
		logic [HEADING_W-1:0]      hdg;
		logic                      last;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [SPACING_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CB-1:0] pos_x = '0;
	logic signed [CB-1:0] pos_y = '0;
	logic signed [CB-1:0] pos_z = '0;
	logic signed [SPEED_W-1:0] speed = '0;
	logic [HEADING_W-1:0] heading = '0;
	logic path_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CB-1:0] out_x;
	logic signed [CB-1:0] out_y;
	logic signed [CB-1:0] out_z;
	logic signed [SPEED_W-1:0] out_speed;
	logic [HEADING_W-1:0] out_heading;
	logic out_last;

	// stimulus and expected kept points
	point_t path_points_q[$];
	point_t kept_points_q[$];
	int points_pushed = 0;
	int points_taken = 0;
	int words_seen = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	// decimation state mirrored in the bench
	logic held_valid = 1'b0;
	point_t held = '0;
	logic [SPACING_W-1:0] spacing_cfg = SPACING_RST;

	always #4 clk = ~clk;

	path_point_spacing_filter_core #(
		.COORD_BITS(CB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.speed(speed),
		.heading(heading),
		.path_end(path_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.out_speed(out_speed),
		.out_heading(out_heading),
		.out_last(out_last)
	);

	// Work out the kept points that one accepted path point releases.
	task automatic advance_filter(input point_t p);
		longint sdx, sdy;
		longint unsigned adx, ady, d2, lim;
		point_t w;
		if (!held_valid) begin
			held = p;
			held_valid = 1'b1;
		end else begin
			sdx = longint'($signed(p.x)) - longint'($signed(held.x));
			sdy = longint'($signed(p.y)) - longint'($signed(held.y));
			adx = (sdx < 0) ? -sdx : sdx;
			ady = (sdy < 0) ? -sdy : sdy;
			d2 = adx * adx + ady * ady;
			lim = longint'(spacing_cfg) * longint'(spacing_cfg);
			if (d2 > lim) begin
				w = held;
				w.last = 1'b0;
				kept_points_q.insert(kept_points_q.size(), w);
				held = p;
			end else if ($signed(p.spd) < $signed(held.spd)) begin
				held.spd = p.spd;
			end
		end
		if (p.last) begin
			w = held;
			w.last = 1'b1;
			kept_points_q.insert(kept_points_q.size(), w);
			held_valid = 1'b0;
		end
	endtask

	task automatic check_word(input point_t got);
		point_t want;
		int bad;
		if (kept_points_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: x=%0d y=%0d z=%0d spd=%0d hdg=%0d last=%0b",
					got.x, got.y, got.z, got.spd, got.hdg, got.last);
		end else begin
			want = kept_points_q.pop_front();
			bad = int'(want.x !== got.x) + int'(want.y !== got.y) + int'(want.z !== got.z)
				+ int'(want.spd !== got.spd) + int'(want.hdg !== got.hdg)
				+ int'(want.last !== got.last);
			if (bad != 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("word %0d mismatch in %0d field(s)", words_seen, bad);
					$display("  exp x=%0d y=%0d z=%0d spd=%0d hdg=%0d last=%0b",
						want.x, want.y, want.z, want.spd, want.hdg, want.last);
					$display("  got x=%0d y=%0d z=%0d spd=%0d hdg=%0d last=%0b",
						got.x, got.y, got.z, got.spd, got.hdg, got.last);
				end
			end
		end
	endtask

	// Driver: bursts of random length with random gaps between them.
	int burst_left = 1;
	int gap_left = 0;
	always @(posedge clk) begin
		point_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && in_stall)) begin
			if (gap_left != 0 || path_points_q.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end else begin
				nxt = path_points_q.pop_front();
				in_valid <= 1'b1;
				pos_x <= nxt.x;
				pos_y <= nxt.y;
				pos_z <= nxt.z;
				speed <= nxt.spd;
				heading <= nxt.hdg;
				path_end <= nxt.last;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// Monitor: predict on accepted points, check accepted words, drive stall.
	int stall_left = 0;
	int stall_mode = 0;
	int hold_left = 0;
	logic long_hold_done = 1'b0;
	always @(posedge clk) begin
		point_t got;
		logic stall_nxt;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				got.x = pos_x;
				got.y = pos_y;
				got.z = pos_z;
				got.spd = speed;
				got.hdg = heading;
				got.last = path_end;
				advance_filter(got);
				points_taken++;
			end
			if (out_valid && !out_stall) begin
				got.x = out_x;
				got.y = out_y;
				got.z = out_z;
				got.spd = out_speed;
				got.hdg = out_heading;
				got.last = out_last;
				check_word(got);
				words_seen++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;

			// hold off the output once for a long stretch so the input backs up
			if (!long_hold_done && words_seen >= 60) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (stall_left == 0) begin
				stall_left = $urandom_range(10, 80);
				stall_mode = $urandom_range(0, 3);
			end
			stall_left--;
			case (stall_mode)
				0: stall_nxt = 1'b0;
				1: stall_nxt = ($urandom_range(0, 3) == 0);
				2: stall_nxt = ($urandom_range(0, 1) == 0);
				default: stall_nxt = ($urandom_range(0, 9) != 0);
			endcase
			if (hold_left != 0) begin
				hold_left--;
				stall_nxt = 1'b1;
			end
			out_stall <= stall_nxt;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("[path_point_spacing_filter_core] ERROR");
		$finish;
	end

	task automatic push_point(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
			input logic signed [CB-1:0] z, input logic signed [SPEED_W-1:0] spd,
			input logic [HEADING_W-1:0] hdg, input logic last);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		p.spd = spd;
		p.hdg = hdg;
		p.last = last;
		path_points_q.insert(path_points_q.size(), p);
		points_pushed++;
	endtask

	function automatic logic signed [CB-1:0] rand_coord();
		return CB'($urandom);
	endfunction

	function automatic logic signed [CB-1:0] pick_base();
		case ($urandom_range(0, 15))
			0: return C_MAX;
			1: return C_MIN;
			default: return rand_coord();
		endcase
	endfunction

	function automatic int rand_step(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Mostly well-formed paths with random content, the rest lone noise points.
	task automatic add_random_paths(input int n_items);
		int made, len, k, s, r;
		logic signed [CB-1:0] px, py;
		made = 0;
		s = int'(spacing_cfg);
		while (made < n_items) begin
			if ($urandom_range(0, 7) == 0) begin
				push_point(rand_coord(), rand_coord(), rand_coord(), SPEED_W'($urandom),
					HEADING_W'($urandom), 1'($urandom_range(0, 1)));
				made++;
			end else begin
				len = $urandom_range(1, 12);
				px = pick_base();
				py = pick_base();
				for (k = 0; k < len; k++) begin
					r = $urandom_range(0, 9);
					if (k == 1 && r < 3) begin
						// land exactly on the spacing circle around the first point
						case ($urandom_range(0, 3))
							0: px = CB'(px + s);
							1: px = CB'(px - s);
							2: py = CB'(py + s);
							default: py = CB'(py - s);
						endcase
					end else if (k != 0 && r == 9) begin
						px = rand_coord();
						py = rand_coord();
					end else if (k != 0) begin
						px = CB'(px + rand_step(s + 3));
						py = CB'(py + rand_step(s + 3));
					end
					push_point(px, py, rand_coord(), SPEED_W'($urandom),
						HEADING_W'($urandom), k == len - 1);
					made++;
				end
			end
		end
	endtask

	task automatic wait_drained();
		while (points_taken != points_pushed || kept_points_q.size() != 0)
			@(posedge clk);
		// let points that release nothing settle inside the block
		repeat (6) @(posedge clk);
	endtask

	task automatic set_spacing(input logic [SPACING_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		spacing_cfg = v;
	endtask

	initial begin
		logic [SPACING_W-1:0] spacings[5];
		int i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed paths at the reset spacing of 10 mm
		push_point(0, 0, 5, 100, 1, 1'b0);
		push_point(10, 0, 6, 50, 2, 1'b0);
		push_point(6, -8, 7, 80, 3, 1'b0);
		push_point(-11, 0, 8, -5, 4, 1'b0);
		push_point(-11, 10, 9, -300, 5, 1'b1);
		push_point(C_MAX, C_MAX, C_MAX, 16'sh7fff, 16'hffff, 1'b1);
		push_point(C_MIN, C_MIN, C_MIN, 16'sh8000, 16'h0000, 1'b1);
		push_point(C_MAX, 0, 0, 0, 16'h5555, 1'b0);
		push_point(C_MIN, 0, 1, 1, 16'haaaa, 1'b1);
		push_point(0, C_MIN, 2, -1, 16'h00ff, 1'b0);
		push_point(0, C_MAX, 3, 2, 16'hff00, 1'b1);
		push_point(C_MAX, C_MAX, 4, 7, 16'h1234, 1'b0);
		push_point(C_MIN, C_MIN, 5, 6, 16'h4321, 1'b1);
		push_point(7, 7, -1, 20, 10, 1'b0);
		push_point(7, 7, -2, 30, 11, 1'b0);
		push_point(7, 7, -3, 16'sh8000, 12, 1'b0);
		push_point(18, 7, -4, 16'sh7fff, 13, 1'b0);
		push_point(18, 7, -5, 16'sh7ffe, 14, 1'b1);
		add_random_paths(PHASE_ITEMS);
		wait_drained();

		spacings[0] = '0;
		spacings[1] = '1;
		spacings[2] = 16'd1;
		spacings[3] = SPACING_W'($urandom_range(2, 3000));
		spacings[4] = 16'd40;
		for (i = 0; i < 5; i++) begin
			set_spacing(spacings[i]);
			add_random_paths(PHASE_ITEMS);
			wait_drained();
		end

		if (mismatches == 0 && kept_points_q.size() == 0)
			$display("[path_point_spacing_filter_core] OK");
		else
			$display("[path_point_spacing_filter_core] ERROR");
		$finish;
	end

endmodule
